// ----- rtl/trimmed_mean_sensor_normalizer_top_defines.svh -----
// assertion macros shared by the trimmed mean sensor normalizer rtl
`ifndef TRIMMED_MEAN_SENSOR_NORMALIZER_TOP_DEFINES_SVH
`define TRIMMED_MEAN_SENSOR_NORMALIZER_TOP_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define TMSN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define TMSN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TMSN_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMSN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/tmsn_pkg.sv -----
// constants, reset values and helpers of the trimmed mean sensor normalizer
package tmsn_pkg;

    // channel and field widths
    localparam int CHANNELS    = 8;
    localparam int CH_W        = 3;
    localparam int CH_SLOTS    = 2 ** CH_W;
    localparam int SAMPLE_W    = 12;
    localparam int COUNT_W     = 4;
    localparam int SUM_W       = 16;
    localparam int LANE_W      = 16;
    localparam int NORM_W      = 14;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    // window and scaling constants
    localparam int WINDOW_LEN  = 10;
    localparam int TRIM_SHIFT  = 3;
    localparam int CLAMP_LEVEL = 4000;
    localparam int LOW_FLOOR   = 10;
    localparam int FULL_SCALE  = 10000;
    localparam int CLAMP_CH_A  = 2;
    localparam int CLAMP_CH_B  = 5;

    // divider: quotient below full scale fits NORM_W bits
    localparam int DIV_STEPS   = NORM_W;
    localparam int STEP_W      = 4;
    localparam int PROD_W      = SAMPLE_W + NORM_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX_HI = 2'd3;

    // configuration reset values
    localparam logic [CFG_W-1:0] CAL_MIN_LO_RST = 64'h0096012C00960096;
    localparam logic [CFG_W-1:0] CAL_MIN_HI_RST = 64'h00960096012C012C;
    localparam logic [CFG_W-1:0] CAL_MAX_LO_RST = 64'h07D00ED807D007D0;
    localparam logic [CFG_W-1:0] CAL_MAX_HI_RST = 64'h07D007D00ED81130;

    // window reset values
    localparam logic [SAMPLE_W-1:0] MIN_RST = '1;

    // pick the 16-bit lane of a channel from a low/high register pair
    function automatic logic [LANE_W-1:0] lane16(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [CH_W-1:0]  ch
    );
        logic [CFG_W-1:0] w;
        w = ch[CH_W-1] ? hi : lo;
        return w[{ch[1:0], 4'b0000} +: LANE_W];
    endfunction

endpackage

// ----- rtl/trimmed_mean_sensor_normalizer_top.sv -----
// Trimmed mean sensor normalizer.
// Input channel (i_in_valid / o_in_stall) carries a channel tag and a 12-bit
// sample. Each channel keeps a ten-sample window as count, sum, min and max.
// The tenth sample of a channel yields one result beat on the output channel
// (o_out_valid / i_out_stall): the mean of the middle eight samples (clamped
// to 4000 on channels 2 and 5) and its position between the channel's
// calibration min and max in hundredths of a percent. Other samples give no
// result. Calibration is written through the cfg port (always ready); the
// user must write it only while the block is idle; the block does not check.
// Sequence: a sample that does not close a window passes S_ACC and S_LVL. A
// closing sample goes via S_CMP to S_DONE if the level saturates, sits at or
// below the minimum or the calibration max is not above the min, else via
// S_MUL and a 14-step restoring divider, one quotient bit per cycle. The
// result lands in an output register, so the next sample is taken while the
// result waits; the sequencer holds a second result in S_DONE during a stall.
// Reset (synchronous, active low) clears all windows, loads the default
// calibration and empties the output register.
module trimmed_mean_sensor_normalizer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tmsn_pkg::CH_W-1:0]           i_channel,
    input  logic [tmsn_pkg::SAMPLE_W-1:0]       i_sample,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tmsn_pkg::CH_W-1:0]           o_out_channel,
    output logic [tmsn_pkg::SAMPLE_W-1:0]       o_filtered_level,
    output logic [tmsn_pkg::NORM_W-1:0]         o_normalized_level,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tmsn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tmsn_pkg::CFG_W-1:0]          i_cfg_data
);

`include "trimmed_mean_sensor_normalizer_top_defines.svh"

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ACC  = 7'b0000010,
        S_LVL  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam int SW = tmsn_pkg::SAMPLE_W;
    localparam int LW = tmsn_pkg::LANE_W;
    localparam int NW = tmsn_pkg::NORM_W;

    t_state r_state, n_state;

    // per-channel window state
    logic [tmsn_pkg::COUNT_W-1:0] r_cnt [tmsn_pkg::CH_SLOTS];
    logic [tmsn_pkg::SUM_W-1:0]   r_sum [tmsn_pkg::CH_SLOTS];
    logic [SW-1:0]                r_min [tmsn_pkg::CH_SLOTS];
    logic [SW-1:0]                r_max [tmsn_pkg::CH_SLOTS];

    // calibration registers
    logic [tmsn_pkg::CFG_W-1:0] r_cal_min_lo, r_cal_min_hi, r_cal_max_lo, r_cal_max_hi;

    // working registers of the sequencer
    logic [tmsn_pkg::CH_W-1:0]   r_ch;
    logic [SW-1:0]               r_smp;
    logic [SW-1:0]               r_x;
    logic [LW-1:0]               r_m, r_mx;
    logic [SW-1:0]               r_xm;
    logic [LW-1:0]               r_den;
    logic [LW-1:0]               r_rem, n_rem;
    logic [NW-1:0]               r_lo;
    logic [tmsn_pkg::STEP_W-1:0] r_step;
    logic [NW-1:0]               r_nl;

    // output register
    logic                        r_out_valid;
    logic [tmsn_pkg::CH_W-1:0]   r_out_ch;
    logic [SW-1:0]               r_out_lvl;
    logic [NW-1:0]               r_out_nl;

    logic                        in_take;
    logic                        ch_ok;
    logic                        out_free;
    logic                        win_done;
    logic [tmsn_pkg::SUM_W:0]    lvl_full;
    logic [SW-1:0]               lvl_raw, lvl;
    logic                        clamp_ch;
    logic                        x_le_m, mx_eq_m, mx_lt_m, sat_hi;
    logic [LW-1:0]               den;
    logic [SW-1:0]               xm;
    logic [tmsn_pkg::PROD_W-1:0] prod;
    logic [LW:0]                 trial;
    logic [LW:0]                 trial_diff;
    logic                        q_bit;

    // handshake
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign ch_ok       = (32'(i_channel) < tmsn_pkg::CHANNELS);

    // trimmed mean of the current channel's window
    assign win_done = (r_cnt[r_ch] == tmsn_pkg::COUNT_W'(tmsn_pkg::WINDOW_LEN));
    assign lvl_full = {1'b0, r_sum[r_ch]} - 17'(r_min[r_ch]) - 17'(r_max[r_ch]);
    assign lvl_raw  = lvl_full[tmsn_pkg::TRIM_SHIFT +: SW];
    assign clamp_ch = (r_ch == tmsn_pkg::CH_W'(tmsn_pkg::CLAMP_CH_A))
                   || (r_ch == tmsn_pkg::CH_W'(tmsn_pkg::CLAMP_CH_B));
    assign lvl      = (clamp_ch && (lvl_raw > SW'(tmsn_pkg::CLAMP_LEVEL)))
                    ? SW'(tmsn_pkg::CLAMP_LEVEL) : lvl_raw;

    // range checks against calibration
    assign x_le_m  = ({4'b0000, r_x} <= r_m);
    assign mx_eq_m = (r_mx == r_m);
    assign mx_lt_m = (r_mx < r_m);
    assign den     = r_mx - r_m;
    assign xm      = r_x - r_m[SW-1:0];
    assign sat_hi  = ({4'b0000, xm} >= den);

    // scale by full scale
    assign prod = tmsn_pkg::PROD_W'(r_xm) * tmsn_pkg::PROD_W'(tmsn_pkg::FULL_SCALE);

    // one restoring division step
    assign trial      = {r_rem, r_lo[NW-1]};
    assign trial_diff = trial - {1'b0, r_den};
    assign q_bit      = !trial_diff[LW];
    assign n_rem      = q_bit ? trial_diff[LW-1:0] : trial[LW-1:0];

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take && ch_ok) n_state = S_ACC;
            end
            S_ACC:  n_state = S_LVL;
            S_LVL: begin
                n_state = win_done ? S_CMP : S_IDLE;
            end
            S_CMP: begin
                if (x_le_m || mx_eq_m || mx_lt_m || sat_hi) n_state = S_DONE;
                else n_state = S_MUL;
            end
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (r_step == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // calibration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_min_lo <= tmsn_pkg::CAL_MIN_LO_RST;
            r_cal_min_hi <= tmsn_pkg::CAL_MIN_HI_RST;
            r_cal_max_lo <= tmsn_pkg::CAL_MAX_LO_RST;
            r_cal_max_hi <= tmsn_pkg::CAL_MAX_HI_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tmsn_pkg::CFG_CAL_MIN_LO: r_cal_min_lo <= i_cfg_data;
                tmsn_pkg::CFG_CAL_MIN_HI: r_cal_min_hi <= i_cfg_data;
                tmsn_pkg::CFG_CAL_MAX_LO: r_cal_max_lo <= i_cfg_data;
                tmsn_pkg::CFG_CAL_MAX_HI: r_cal_max_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window accumulate and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tmsn_pkg::CH_SLOTS; i++) begin
                r_cnt[i] <= '0;
                r_sum[i] <= '0;
                r_min[i] <= tmsn_pkg::MIN_RST;
                r_max[i] <= '0;
            end
        end else if (r_state == S_ACC) begin
            r_sum[r_ch] <= r_sum[r_ch] + tmsn_pkg::SUM_W'(r_smp);
            r_cnt[r_ch] <= r_cnt[r_ch] + 1'b1;
            if (r_smp < r_min[r_ch]) r_min[r_ch] <= r_smp;
            if (r_smp > r_max[r_ch]) r_max[r_ch] <= r_smp;
        end else if (r_state == S_LVL && win_done) begin
            r_cnt[r_ch] <= '0;
            r_sum[r_ch] <= '0;
            r_min[r_ch] <= tmsn_pkg::MIN_RST;
            r_max[r_ch] <= '0;
        end
    end

    // datapath of the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ch  <= i_channel;
                r_smp <= i_sample;
            end
            S_LVL: begin
                r_x  <= lvl;
                r_m  <= tmsn_pkg::lane16(r_cal_min_lo, r_cal_min_hi, r_ch);
                r_mx <= tmsn_pkg::lane16(r_cal_max_lo, r_cal_max_hi, r_ch);
            end
            S_CMP: begin
                r_xm  <= xm;
                r_den <= den;
                if (x_le_m || mx_lt_m) r_nl <= NW'(tmsn_pkg::LOW_FLOOR);
                else                   r_nl <= NW'(tmsn_pkg::FULL_SCALE);
            end
            S_MUL: begin
                r_rem  <= LW'(prod[tmsn_pkg::PROD_W-1:NW]);
                r_lo   <= prod[NW-1:0];
                r_step <= tmsn_pkg::STEP_W'(tmsn_pkg::DIV_STEPS - 1);
            end
            S_DIV: begin
                r_rem  <= n_rem;
                r_lo   <= {r_lo[NW-2:0], q_bit};
                r_step <= r_step - 1'b1;
                if (r_step == '0) r_nl <= {r_lo[NW-2:0], q_bit};
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_ch  <= r_ch;
            r_out_lvl <= r_x;
            r_out_nl  <= r_nl;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_channel      = r_out_ch;
    assign o_filtered_level   = r_out_lvl;
    assign o_normalized_level = r_out_nl;

    // checks
    `TMSN_ASSERT(a_take_starts_acc, i_clk, i_rst_n,
        (in_take && ch_ok) |=> (r_state == S_ACC), "accepted sample did not start accumulation")
    `TMSN_ASSERT(a_rem_below_den, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (r_rem < r_den), "divider remainder not below divisor")
    `TMSN_ASSERT(a_hold_when_full, i_clk, i_rst_n,
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE),
        "result dropped while output register full")
    `TMSN_ASSERT_NEVER(a_norm_range, i_clk, i_rst_n,
        r_out_valid && (r_out_nl > NW'(tmsn_pkg::FULL_SCALE)), "normalized level above full scale")

endmodule

// ----- dv/trimmed_mean_sensor_normalizer_top_tb.sv -----
// self-checking testbench of the trimmed mean sensor normalizer: random windows, calibration sweeps
module trimmed_mean_sensor_normalizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmsn_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum int {CAL_MIXED, CAL_WIDE, CAL_RANDOM, CAL_INVERTED} cal_style_e;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] level;
        logic [NORM_W-1:0]   norm;
    } level_result_t;

    // per-channel window tracking and normalized level prediction
    class level_scoreboard;
        logic [CFG_W-1:0]    cal [4];
        logic [COUNT_W-1:0]  win_count [CH_SLOTS];
        logic [SUM_W-1:0]    win_sum [CH_SLOTS];
        logic [SAMPLE_W-1:0] win_min [CH_SLOTS];
        logic [SAMPLE_W-1:0] win_max [CH_SLOTS];
        level_result_t       expected_levels [$];
        int                  fault_count;

        function void clear_state();
            cal[CFG_CAL_MIN_LO] = CAL_MIN_LO_RST;
            cal[CFG_CAL_MIN_HI] = CAL_MIN_HI_RST;
            cal[CFG_CAL_MAX_LO] = CAL_MAX_LO_RST;
            cal[CFG_CAL_MAX_HI] = CAL_MAX_HI_RST;
            for (int c = 0; c < CH_SLOTS; c++) clear_window(c);
            fault_count = 0;
        endfunction

        function void clear_window(int c);
            win_count[c] = '0;
            win_sum[c]   = '0;
            win_min[c]   = '1;
            win_max[c]   = '0;
        endfunction

        function void set_cal(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            cal[idx] = data;
        endfunction

        // calibration lane of a channel, min or max
        function logic [LANE_W-1:0] cal_lane(bit want_max, logic [CH_W-1:0] ch);
            logic [CFG_W-1:0] word;
            if (want_max) word = ch[2] ? cal[CFG_CAL_MAX_HI] : cal[CFG_CAL_MAX_LO];
            else          word = ch[2] ? cal[CFG_CAL_MIN_HI] : cal[CFG_CAL_MIN_LO];
            return LANE_W'(word >> (int'(ch[1:0]) * LANE_W));
        endfunction

        // hundredths of a percent between calibration min and max
        function logic [NORM_W-1:0] position(logic [SAMPLE_W-1:0] x,
                                             logic [LANE_W-1:0] lo_cal,
                                             logic [LANE_W-1:0] hi_cal);
            logic [63:0] q;
            if (x <= lo_cal) return NORM_W'(LOW_FLOOR);
            if (hi_cal == lo_cal) return NORM_W'(FULL_SCALE);
            if (hi_cal < lo_cal) return NORM_W'(LOW_FLOOR);
            q = ((64'(x) - 64'(lo_cal)) * 64'(FULL_SCALE)) / (64'(hi_cal) - 64'(lo_cal));
            if (q > 64'(FULL_SCALE)) q = 64'(FULL_SCALE);
            return q[NORM_W-1:0];
        endfunction

        // accepted sample: update window, expect a result when it closes
        function void note_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] s);
            logic [SUM_W-1:0] trimmed;
            level_result_t    r;
            win_sum[ch] = win_sum[ch] + SUM_W'(s);
            if (s < win_min[ch]) win_min[ch] = s;
            if (s > win_max[ch]) win_max[ch] = s;
            win_count[ch] = win_count[ch] + 1'b1;
            if (win_count[ch] < WINDOW_LEN) return;
            trimmed = (win_sum[ch] - SUM_W'(win_min[ch]) - SUM_W'(win_max[ch])) >> TRIM_SHIFT;
            if ((ch == CLAMP_CH_A || ch == CLAMP_CH_B) && trimmed > CLAMP_LEVEL)
                trimmed = SUM_W'(CLAMP_LEVEL);
            r.ch    = ch;
            r.level = trimmed[SAMPLE_W-1:0];
            r.norm  = position(r.level, cal_lane(1'b0, ch), cal_lane(1'b1, ch));
            expected_levels.push_back(r);
            clear_window(ch);
        endfunction

        // result beat against the oldest expectation
        function void check_result(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] level,
                                   logic [NORM_W-1:0] norm);
            level_result_t e;
            if (expected_levels.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: ch %0d level %0d norm %0d", ch, level, norm);
                return;
            end
            e = expected_levels.pop_front();
            if (e.ch !== ch || e.level !== level || e.norm !== norm) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("mismatch: exp ch %0d level %0d norm %0d, got ch %0d level %0d norm %0d",
                             e.ch, e.level, e.norm, ch, level, norm);
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CH_W-1:0]       i_channel;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CH_W-1:0]       o_out_channel;
    logic [SAMPLE_W-1:0]   o_filtered_level;
    logic [NORM_W-1:0]     o_normalized_level;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    level_scoreboard sb;
    idle_mode_e      idle_mode = IDLE_NONE;
    bit              hold_req  = 1'b0;
    int              hold_left = 0;
    int              aim [CH_SLOTS];

    trimmed_mean_sensor_normalizer_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_channel          (i_channel),
        .i_sample           (i_sample),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_channel      (o_out_channel),
        .o_filtered_level   (o_filtered_level),
        .o_normalized_level (o_normalized_level),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // receiver stall, with the long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= roll(idle_mode == IDLE_RECEIVER ? 87 :
                                idle_mode == IDLE_BOTH ? 15 : 0);
        end
    end

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_result(o_out_channel, o_filtered_level, o_normalized_level);
    end

    // one sample beat, entered and left at a falling edge
    task automatic send_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] s);
        int gap_pct;
        gap_pct = idle_mode == IDLE_SENDER ? 87 : idle_mode == IDLE_BOTH ? 15 : 0;
        while (roll(gap_pct)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_channel  <= ch;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_sample(ch, s);
        @(negedge i_clk);
    endtask

    // one config beat, valid left high for a following beat
    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_cal(idx, data);
        @(negedge i_clk);
    endtask

    task automatic write_all_cal(logic [CFG_W-1:0] mn_lo, logic [CFG_W-1:0] mn_hi,
                                 logic [CFG_W-1:0] mx_lo, logic [CFG_W-1:0] mx_hi);
        cfg_beat(CFG_CAL_MIN_LO, mn_lo);
        cfg_beat(CFG_CAL_MIN_HI, mn_hi);
        cfg_beat(CFG_CAL_MAX_LO, mx_lo);
        cfg_beat(CFG_CAL_MAX_HI, mx_hi);
        i_cfg_valid <= 1'b0;
    endtask

    // wait out every expected result, then the worst divider latency
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // calibration set for a phase
    task automatic make_cal(cal_style_e style, output logic [CFG_W-1:0] mn_lo,
                            output logic [CFG_W-1:0] mn_hi, output logic [CFG_W-1:0] mx_lo,
                            output logic [CFG_W-1:0] mx_hi);
        logic [LANE_W-1:0] mn;
        logic [LANE_W-1:0] mx;
        mn_lo = '0; mn_hi = '0; mx_lo = '0; mx_hi = '0;
        for (int c = 0; c < CH_SLOTS; c++) begin
            case (style)
                CAL_WIDE: begin
                    mn = '0; mx = '1;
                end
                CAL_INVERTED: begin
                    mn = '1; mx = '0;
                end
                CAL_RANDOM: begin
                    mn = LANE_W'($urandom); mx = LANE_W'($urandom);
                end
                default: begin
                    case ($urandom_range(7))
                        0, 1, 2: begin
                            mn = LANE_W'($urandom_range(3000));
                            mx = mn + LANE_W'($urandom_range(1500, 1));
                        end
                        3: begin
                            mn = LANE_W'($urandom_range(4095)); mx = mn;
                        end
                        4: begin
                            mn = LANE_W'($urandom_range(4095, 1));
                            mx = LANE_W'($urandom_range(int'(mn) - 1));
                        end
                        5: begin
                            mn = LANE_W'($urandom_range(200)); mx = LANE_W'($urandom);
                        end
                        default: begin
                            mn = LANE_W'($urandom); mx = LANE_W'($urandom);
                        end
                    endcase
                end
            endcase
            if (c < 4) begin
                mn_lo[c*LANE_W +: LANE_W] = mn;
                mx_lo[c*LANE_W +: LANE_W] = mx;
            end else begin
                mn_hi[(c-4)*LANE_W +: LANE_W] = mn;
                mx_hi[(c-4)*LANE_W +: LANE_W] = mx;
            end
        end
    endtask

    // sample aimed per window near the calibration points, with outliers
    function automatic logic [SAMPLE_W-1:0] next_sample(logic [CH_W-1:0] ch);
        int lo_v;
        int hi_v;
        int v;
        lo_v = int'(sb.cal_lane(1'b0, ch));
        hi_v = int'(sb.cal_lane(1'b1, ch));
        if (sb.win_count[ch] == 0) begin
            case ($urandom_range(9))
                0: aim[ch] = 0;
                1: aim[ch] = 4095;
                2: aim[ch] = int'($urandom_range(4095));
                3, 4: aim[ch] = lo_v + int'($urandom_range(8)) - 4;
                5, 6: aim[ch] = hi_v + int'($urandom_range(8)) - 4;
                default: aim[ch] = lo_v + ((hi_v - lo_v) * int'($urandom_range(100))) / 100;
            endcase
        end
        if ($urandom_range(11) == 0) v = int'($urandom_range(4095));
        else v = aim[ch] + int'($urandom_range(12)) - 6;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    // run limit
    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial begin
        logic [CH_W-1:0]  ch;
        logic [CFG_W-1:0] mn_lo;
        logic [CFG_W-1:0] mn_hi;
        logic [CFG_W-1:0] mx_lo;
        logic [CFG_W-1:0] mx_hi;
        cal_style_e       styles [6];

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_channel   = '0;
        i_sample    = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CAL_MIN_LO;
        i_cfg_data  = '0;
        sb = new;
        sb.clear_state();
        styles = '{CAL_MIXED, CAL_WIDE, CAL_MIXED, CAL_RANDOM, CAL_INVERTED, CAL_MIXED};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: ch0 zero window at min 0, ch2 full-scale window clamped
        // and saturating, ch7 level one above its min giving a zero quotient
        write_all_cal({16'd150, 16'd3999, 16'd150, 16'd0},
                      {16'd100, 16'd150, 16'd300, 16'd300},
                      {16'd2000, 16'd4000, 16'd2000, 16'd1000},
                      {16'hFFFF, 16'd2000, 16'd3800, 16'd4400});
        for (int i = 0; i < 10; i++) begin
            send_sample(3'd2, 12'd4095);
            send_sample(3'd0, 12'd0);
        end
        for (int i = 0; i < 10; i++) send_sample(3'd7, 12'd101);
        drain();

        // random phases, each with its own calibration and idling pattern
        for (int ph = 0; ph < 6; ph++) begin
            idle_mode = idle_mode_e'(ph % 4);
            make_cal(styles[ph], mn_lo, mn_hi, mx_lo, mx_hi);
            write_all_cal(mn_lo, mn_hi, mx_lo, mx_hi);
            if (ph == 0) hold_req = 1'b1;
            repeat (290) begin
                ch = CH_W'($urandom_range(CHANNELS - 1));
                send_sample(ch, next_sample(ch));
            end
            drain();
        end

        if (sb.pending() != 0) $display("results missing: %0d", sb.pending());
        if (sb.fault_count == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tmsn_pkg.sv
rtl/trimmed_mean_sensor_normalizer_top.sv
dv/trimmed_mean_sensor_normalizer_top_tb.sv
